// ===== src/serial_request_response_framer_core_assert.svh =====
// assertion macros for the serial request-response framer
// used by the checker module, no other dependencies
`ifndef SERIAL_REQUEST_RESPONSE_FRAMER_CORE_ASSERT_SVH
`define SERIAL_REQUEST_RESPONSE_FRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define SRRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("srrf assertion failed");

// next-cycle implication
`define SRRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("srrf assertion failed");

`endif

// ===== src/srrf_pkg.sv =====
// shared types and constants of the serial request-response framer
// no dependencies
package srrf_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t FRAME_HEAD = 8'h7E;
  localparam byte_t FRAME_TAIL = 8'h0D;
  localparam byte_t CAP_RESET  = 8'hFF;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_SLOT  = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;

  typedef enum logic [14:0] {
    PH_IDLE   = 15'b000000000000001,
    PH_Q_HEAD = 15'b000000000000010,
    PH_Q_ADDR = 15'b000000000000100,
    PH_Q_OP   = 15'b000000000001000,
    PH_Q_LEN  = 15'b000000000010000,
    PH_Q_DATA = 15'b000000000100000,
    PH_Q_CHK  = 15'b000000001000000,
    PH_Q_TAIL = 15'b000000010000000,
    PH_R_HEAD = 15'b000000100000000,
    PH_R_ADDR = 15'b000001000000000,
    PH_R_OP   = 15'b000010000000000,
    PH_R_LEN  = 15'b000100000000000,
    PH_R_DATA = 15'b001000000000000,
    PH_R_CHK  = 15'b010000000000000,
    PH_R_TAIL = 15'b100000000000000
  } phase_e;

  typedef struct packed {
    phase_e phase;
    byte_t  xor_acc;
    byte_t  sum_acc;
    byte_t  byte_count;
    byte_t  rx_len;
    byte_t  addr;
    byte_t  opcode;
    byte_t  req_len;
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    byte_t      frame_address;
    byte_t      frame_opcode;
    byte_t      payload_length;
    byte_t      data_byte;
  } item_t;

  typedef struct packed {
    logic  tx_valid;
    byte_t tx_byte;
    logic  payload_valid;
    logic  payload_keep;
    byte_t payload_index;
    byte_t payload_byte;
    logic  finished;
    logic  status;
    byte_t response_length;
  } result_t;

endpackage

// ===== src/srrf_if.sv =====
// channel interfaces of the serial request-response framer
// depends on srrf_pkg
interface srrf_req_if import srrf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  byte_t      frame_address;
  byte_t      frame_opcode;
  byte_t      payload_length;
  byte_t      data_byte;

  modport source (output valid, command, frame_address, frame_opcode, payload_length,
                  data_byte, input ready);
  modport sink (input valid, command, frame_address, frame_opcode, payload_length,
                data_byte, output ready);
endinterface

interface srrf_rsp_if import srrf_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  tx_valid;
  byte_t tx_byte;
  logic  payload_valid;
  logic  payload_keep;
  byte_t payload_index;
  byte_t payload_byte;
  logic  finished;
  logic  status;
  byte_t response_length;

  modport source (output valid, tx_valid, tx_byte, payload_valid, payload_keep,
                  payload_index, payload_byte, finished, status, response_length,
                  input ready);
  modport sink (input valid, tx_valid, tx_byte, payload_valid, payload_keep,
                payload_index, payload_byte, finished, status, response_length,
                output ready);
endinterface

interface srrf_cfg_if import srrf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/serial_request_response_framer_core.sv =====
// top level of the serial request-response framer, master side
// depends on srrf_pkg, srrf_if and srrf_step
//
// req_i carries one item per handshake: a start, a free transmit slot or a
// received byte. rsp_o returns exactly one result per item, in order: the
// next request byte to send, a response payload byte with index and keep
// flag, and the end-of-exchange flag with its status.
// cfg_i writes the response capacity (reset 255); write it only while idle.
// each item is handled by the combinational step logic and lands in the
// result register, so a result is offered in the cycle after its item is taken.
// throughput is one item per cycle unless rsp_o.ready is low; req_i.ready is
// high whenever the result register is empty or is being taken in the same cycle.
// when rsp_o.ready stays low the result holds and req_i.ready drops until
// the result is taken; nothing is dropped.
// reset puts the exchange in idle with all counters and checksums cleared
// and the result register empty.
module serial_request_response_framer_core import srrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  srrf_req_if.sink   req_i,
  srrf_rsp_if.source rsp_o,
  srrf_cfg_if.sink   cfg_i
);

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    valid_q;
  byte_t   cap_q;
  item_t   item;
  logic    accept;

  assign item = '{command:        req_i.command,
                  frame_address:  req_i.frame_address,
                  frame_opcode:   req_i.frame_opcode,
                  payload_length: req_i.payload_length,
                  data_byte:      req_i.data_byte};

  assign req_i.ready = !valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  srrf_step u_step (
    .state_i    (state_q),
    .item_i     (item),
    .capacity_i (cap_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
      valid_q <= 1'b0;
      cap_q   <= CAP_RESET;
    end else begin
      if (accept) begin
        state_q <= state_d;
        valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid           = valid_q;
  assign rsp_o.tx_valid        = res_q.tx_valid;
  assign rsp_o.tx_byte         = res_q.tx_byte;
  assign rsp_o.payload_valid   = res_q.payload_valid;
  assign rsp_o.payload_keep    = res_q.payload_keep;
  assign rsp_o.payload_index   = res_q.payload_index;
  assign rsp_o.payload_byte    = res_q.payload_byte;
  assign rsp_o.finished        = res_q.finished;
  assign rsp_o.status          = res_q.status;
  assign rsp_o.response_length = res_q.response_length;

endmodule

// ===== src/srrf_step.sv =====
// next-state and result logic for one item of the framer
// depends on srrf_pkg
module srrf_step import srrf_pkg::*; (
  input  state_t  state_i,
  input  item_t   item_i,
  input  byte_t   capacity_i,
  output state_t  state_o,
  output result_t result_o
);

  always_comb begin
    byte_t b;
    byte_t xa;
    byte_t sa;
    byte_t exp_chk;
    byte_t cnt_inc;
    logic  err;
    logic  done;

    state_o  = state_i;
    result_o = '0;
    b        = '0;
    err      = 1'b0;
    done     = 1'b0;
    cnt_inc  = state_i.byte_count + 8'd1;
    xa       = (state_i.phase == PH_R_HEAD) ? 8'd0 : state_i.xor_acc;
    sa       = (state_i.phase == PH_R_HEAD) ? 8'd0 : state_i.sum_acc;
    exp_chk  = xa ^ sa;

    unique case (item_i.command)
      CMD_START: begin
        state_o.addr       = item_i.frame_address;
        state_o.opcode     = item_i.frame_opcode;
        state_o.req_len    = item_i.payload_length;
        state_o.byte_count = '0;
        state_o.rx_len     = '0;
        state_o.xor_acc    = '0;
        state_o.sum_acc    = '0;
        state_o.phase      = PH_Q_HEAD;
      end
      CMD_SLOT: begin
        xa = state_i.xor_acc;
        sa = state_i.sum_acc;
        unique case (state_i.phase)
          PH_Q_HEAD: begin
            xa            = '0;
            sa            = '0;
            b             = FRAME_HEAD;
            state_o.phase = PH_Q_ADDR;
          end
          PH_Q_ADDR: begin
            b             = state_i.addr;
            state_o.phase = PH_Q_OP;
          end
          PH_Q_OP: begin
            b             = state_i.opcode;
            state_o.phase = PH_Q_LEN;
          end
          PH_Q_LEN: begin
            b                  = state_i.req_len;
            state_o.byte_count = '0;
            state_o.phase      = (state_i.req_len == 8'd0) ? PH_Q_CHK : PH_Q_DATA;
          end
          PH_Q_DATA: begin
            b                  = item_i.data_byte;
            state_o.byte_count = cnt_inc;
            if (cnt_inc == state_i.req_len) begin
              state_o.phase = PH_Q_CHK;
            end
          end
          PH_Q_CHK: begin
            b             = state_i.xor_acc ^ state_i.sum_acc;
            state_o.phase = PH_Q_TAIL;
          end
          PH_Q_TAIL: begin
            b             = FRAME_TAIL;
            state_o.phase = PH_R_HEAD;
          end
          default: begin
            state_o.phase = (state_i.phase == PH_IDLE || state_i.phase == PH_R_HEAD ||
                             state_i.phase == PH_R_ADDR || state_i.phase == PH_R_OP ||
                             state_i.phase == PH_R_LEN || state_i.phase == PH_R_DATA ||
                             state_i.phase == PH_R_CHK || state_i.phase == PH_R_TAIL)
                            ? state_i.phase : PH_IDLE;
          end
        endcase
        if (state_i.phase == PH_Q_HEAD || state_i.phase == PH_Q_ADDR ||
            state_i.phase == PH_Q_OP || state_i.phase == PH_Q_LEN ||
            state_i.phase == PH_Q_DATA || state_i.phase == PH_Q_CHK ||
            state_i.phase == PH_Q_TAIL) begin
          result_o.tx_valid = 1'b1;
          result_o.tx_byte  = b;
          state_o.xor_acc   = xa ^ b;
          state_o.sum_acc   = sa + b;
        end
      end
      CMD_RX: begin
        unique case (state_i.phase)
          PH_Q_HEAD, PH_Q_ADDR, PH_Q_OP, PH_Q_LEN, PH_Q_DATA, PH_Q_CHK, PH_Q_TAIL: begin
            err = 1'b1;
          end
          PH_R_HEAD: begin
            if (item_i.data_byte == FRAME_HEAD) state_o.phase = PH_R_ADDR;
            else err = 1'b1;
          end
          PH_R_ADDR: begin
            if (item_i.data_byte == state_i.addr) state_o.phase = PH_R_OP;
            else err = 1'b1;
          end
          PH_R_OP: begin
            if (item_i.data_byte == state_i.opcode) state_o.phase = PH_R_LEN;
            else err = 1'b1;
          end
          PH_R_LEN: begin
            state_o.rx_len     = item_i.data_byte;
            state_o.byte_count = '0;
            state_o.phase      = (item_i.data_byte == 8'd0) ? PH_R_CHK : PH_R_DATA;
          end
          PH_R_DATA: begin
            result_o.payload_valid = 1'b1;
            result_o.payload_keep  = (state_i.byte_count < capacity_i);
            result_o.payload_index = state_i.byte_count;
            result_o.payload_byte  = item_i.data_byte;
            state_o.byte_count     = cnt_inc;
            if (cnt_inc == state_i.rx_len) begin
              state_o.phase = PH_R_CHK;
            end
          end
          PH_R_CHK: begin
            if (item_i.data_byte == exp_chk) state_o.phase = PH_R_TAIL;
            else err = 1'b1;
          end
          PH_R_TAIL: begin
            if (item_i.data_byte == FRAME_TAIL) done = 1'b1;
            else err = 1'b1;
          end
          default: begin
            state_o.phase = PH_IDLE;
          end
        endcase
        if (state_i.phase == PH_R_HEAD || state_i.phase == PH_R_ADDR ||
            state_i.phase == PH_R_OP || state_i.phase == PH_R_LEN ||
            state_i.phase == PH_R_DATA || state_i.phase == PH_R_CHK ||
            state_i.phase == PH_R_TAIL) begin
          state_o.xor_acc = xa ^ item_i.data_byte;
          state_o.sum_acc = sa + item_i.data_byte;
        end
        if (err || done) begin
          result_o.finished = 1'b1;
          result_o.status   = err;
          state_o.phase     = PH_IDLE;
        end
      end
      default: begin
        state_o.phase = (state_i.phase == PH_IDLE || state_i.phase == PH_Q_HEAD ||
                         state_i.phase == PH_Q_ADDR || state_i.phase == PH_Q_OP ||
                         state_i.phase == PH_Q_LEN || state_i.phase == PH_Q_DATA ||
                         state_i.phase == PH_Q_CHK || state_i.phase == PH_Q_TAIL ||
                         state_i.phase == PH_R_HEAD || state_i.phase == PH_R_ADDR ||
                         state_i.phase == PH_R_OP || state_i.phase == PH_R_LEN ||
                         state_i.phase == PH_R_DATA || state_i.phase == PH_R_CHK ||
                         state_i.phase == PH_R_TAIL) ? state_i.phase : PH_IDLE;
      end
    endcase

    result_o.response_length = state_o.rx_len;
  end

endmodule

// ===== src/srrf_checker.sv =====
// port-level assertions for the serial request-response framer
// depends on serial_request_response_framer_core_assert.svh, bound to the top level
`include "serial_request_response_framer_core_assert.svh"

module srrf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic tx_valid_i,
  input logic payload_valid_i,
  input logic payload_keep_i,
  input logic finished_i,
  input logic status_i
);

  `SRRF_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `SRRF_ASSERT_IMPL(a_one_kind, clk_i, rst_ni, rsp_valid_i, !(tx_valid_i && (payload_valid_i || finished_i)))
  `SRRF_ASSERT_IMPL(a_status_done, clk_i, rst_ni, rsp_valid_i && status_i, finished_i)
  `SRRF_ASSERT_IMPL(a_keep_payload, clk_i, rst_ni, rsp_valid_i && payload_keep_i, payload_valid_i)

endmodule

bind serial_request_response_framer_core srrf_checker u_srrf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .tx_valid_i      (rsp_o.tx_valid),
  .payload_valid_i (rsp_o.payload_valid),
  .payload_keep_i  (rsp_o.payload_keep),
  .finished_i      (rsp_o.finished),
  .status_i        (rsp_o.status)
);

// ===== tb/tb_serial_request_response_framer_core.sv =====
// self-checking bench for serial_request_response_framer_core: directed and random
// frame exchanges, each result checked against a framer model kept in this file
// depends on srrf_pkg, srrf_if and the rtl of the core
module tb_serial_request_response_framer_core;
  import srrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    FLT_NONE, FLT_HEAD, FLT_ADDR, FLT_OP, FLT_CHK, FLT_TAIL, FLT_RX_EARLY, FLT_RESTART
  } fault_e;

  logic clk_i;
  logic rst_ni;

  srrf_req_if link_req ();
  srrf_rsp_if link_rsp ();
  srrf_cfg_if cap_cfg ();

  serial_request_response_framer_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (link_req),
    .rsp_o  (link_rsp),
    .cfg_i  (cap_cfg)
  );

  item_t   host_items[$];
  result_t expected_link_out[$];
  item_t   req_cur;
  logic    req_taken;
  state_t  fr;
  byte_t   capacity_setting;
  bit      no_gaps;
  int      queued;
  int      mismatches;
  int      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic byte_t rand_byte();
    return byte_t'($urandom);
  endfunction

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(0, 99) < 6);
  endfunction

  function automatic result_t advance_framer(input item_t it);
    result_t r;
    byte_t   b;
    byte_t   want;
    logic    err;
    logic    done;
    r = '0;
    b = '0;
    err = 1'b0;
    done = 1'b0;
    case (it.command)
      CMD_START: begin
        fr.addr = it.frame_address;
        fr.opcode = it.frame_opcode;
        fr.req_len = it.payload_length;
        fr.byte_count = '0;
        fr.rx_len = '0;
        fr.xor_acc = '0;
        fr.sum_acc = '0;
        fr.phase = PH_Q_HEAD;
      end
      CMD_SLOT: begin
        if (fr.phase inside {PH_Q_HEAD, PH_Q_ADDR, PH_Q_OP, PH_Q_LEN, PH_Q_DATA, PH_Q_CHK,
                             PH_Q_TAIL}) begin
          case (fr.phase)
            PH_Q_HEAD: begin
              fr.xor_acc = '0;
              fr.sum_acc = '0;
              b = FRAME_HEAD;
              fr.phase = PH_Q_ADDR;
            end
            PH_Q_ADDR: begin
              b = fr.addr;
              fr.phase = PH_Q_OP;
            end
            PH_Q_OP: begin
              b = fr.opcode;
              fr.phase = PH_Q_LEN;
            end
            PH_Q_LEN: begin
              b = fr.req_len;
              fr.byte_count = '0;
              fr.phase = (fr.req_len == 8'd0) ? PH_Q_CHK : PH_Q_DATA;
            end
            PH_Q_DATA: begin
              b = it.data_byte;
              fr.byte_count = fr.byte_count + 8'd1;
              if (fr.byte_count == fr.req_len) fr.phase = PH_Q_CHK;
            end
            PH_Q_CHK: begin
              b = fr.xor_acc ^ fr.sum_acc;
              fr.phase = PH_Q_TAIL;
            end
            default: begin
              b = FRAME_TAIL;
              fr.phase = PH_R_HEAD;
            end
          endcase
          fr.xor_acc = fr.xor_acc ^ b;
          fr.sum_acc = fr.sum_acc + b;
          r.tx_valid = 1'b1;
          r.tx_byte = b;
        end
      end
      CMD_RX: begin
        if (fr.phase inside {PH_Q_HEAD, PH_Q_ADDR, PH_Q_OP, PH_Q_LEN, PH_Q_DATA, PH_Q_CHK,
                             PH_Q_TAIL}) begin
          err = 1'b1;
        end else if (fr.phase inside {PH_R_HEAD, PH_R_ADDR, PH_R_OP, PH_R_LEN, PH_R_DATA,
                                      PH_R_CHK, PH_R_TAIL}) begin
          if (fr.phase == PH_R_HEAD) begin
            fr.xor_acc = '0;
            fr.sum_acc = '0;
          end
          want = fr.xor_acc ^ fr.sum_acc;
          fr.xor_acc = fr.xor_acc ^ it.data_byte;
          fr.sum_acc = fr.sum_acc + it.data_byte;
          case (fr.phase)
            PH_R_HEAD: begin
              if (it.data_byte == FRAME_HEAD) fr.phase = PH_R_ADDR;
              else err = 1'b1;
            end
            PH_R_ADDR: begin
              if (it.data_byte == fr.addr) fr.phase = PH_R_OP;
              else err = 1'b1;
            end
            PH_R_OP: begin
              if (it.data_byte == fr.opcode) fr.phase = PH_R_LEN;
              else err = 1'b1;
            end
            PH_R_LEN: begin
              fr.rx_len = it.data_byte;
              fr.byte_count = '0;
              fr.phase = (it.data_byte == 8'd0) ? PH_R_CHK : PH_R_DATA;
            end
            PH_R_DATA: begin
              r.payload_valid = 1'b1;
              r.payload_keep = (fr.byte_count < capacity_setting);
              r.payload_index = fr.byte_count;
              r.payload_byte = it.data_byte;
              fr.byte_count = fr.byte_count + 8'd1;
              if (fr.byte_count == fr.rx_len) fr.phase = PH_R_CHK;
            end
            PH_R_CHK: begin
              if (it.data_byte == want) fr.phase = PH_R_TAIL;
              else err = 1'b1;
            end
            default: begin
              if (it.data_byte == FRAME_TAIL) done = 1'b1;
              else err = 1'b1;
            end
          endcase
        end
        if (err || done) begin
          r.finished = 1'b1;
          r.status = err;
          fr.phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    r.response_length = fr.rx_len;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic add_item(input logic [1:0] cmd, input byte_t addr, input byte_t op,
                          input byte_t len, input byte_t data);
    item_t it;
    it.command = cmd;
    it.frame_address = addr;
    it.frame_opcode = op;
    it.payload_length = len;
    it.data_byte = data;
    host_items.push_back(it);
    queued++;
  endtask

  // request frame through the slots, then the response bytes, optionally broken
  task automatic queue_exchange(input byte_t addr, input byte_t op, input byte_t qlen,
                                input byte_t rlen, input fault_e fault, input bit stray);
    byte_t frame[$];
    byte_t x;
    byte_t s;
    int    n_req;
    int    cut;
    int    last;
    n_req = int'(qlen) + 6;
    add_item(CMD_START, addr, op, qlen, rand_byte());
    cut = (fault == FLT_RX_EARLY) ? $urandom_range(0, n_req - 1) : n_req;
    for (int i = 0; i < cut; i++)
      add_item(CMD_SLOT, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    if (fault == FLT_RX_EARLY) begin
      add_item(CMD_RX, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      return;
    end
    if (stray) add_item(CMD_SLOT, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    frame = {FRAME_HEAD, addr, op, rlen};
    repeat (rlen) frame.push_back(rand_byte());
    x = '0;
    s = '0;
    foreach (frame[i]) begin
      x = x ^ frame[i];
      s = s + frame[i];
    end
    frame.push_back(x ^ s);
    frame.push_back(FRAME_TAIL);
    last = frame.size() - 1;
    case (fault)
      FLT_HEAD: frame[0] = frame[0] ^ byte_t'($urandom_range(1, 255));
      FLT_ADDR: frame[1] = frame[1] ^ byte_t'($urandom_range(1, 255));
      FLT_OP:   frame[2] = frame[2] ^ byte_t'($urandom_range(1, 255));
      FLT_CHK:  frame[last - 1] = frame[last - 1] ^ byte_t'($urandom_range(1, 255));
      FLT_TAIL: frame[last] = frame[last] ^ byte_t'($urandom_range(1, 255));
      default: ;
    endcase
    cut = (fault == FLT_RESTART) ? $urandom_range(0, frame.size() - 1) : frame.size();
    for (int i = 0; i < cut; i++)
      add_item(CMD_RX, rand_byte(), rand_byte(), rand_byte(), frame[i]);
  endtask

  function automatic byte_t pick_len();
    if ($urandom_range(0, 99) < 1) return byte_t'($urandom_range(128, 255));
    return byte_t'($urandom_range(0, 6));
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (host_items.size() != 0 || link_req.valid || expected_link_out.size() != 0);
  endtask

  task automatic write_capacity(input byte_t value);
    @(negedge clk_i);
    cap_cfg.valid = 1'b1;
    cap_cfg.data = value;
    do @(posedge clk_i);
    while (!cap_cfg.ready);
    capacity_setting = value;
    @(negedge clk_i);
    cap_cfg.valid = 1'b0;
  endtask

  task automatic run_phase(input byte_t cap, input int target, input bit steady,
                           input bit full_frame);
    int     goal;
    fault_e fault;
    wait_drained();
    write_capacity(cap);
    no_gaps = steady;
    goal = queued + target;
    if (full_frame) queue_exchange(rand_byte(), rand_byte(), 8'd3, 8'd255, FLT_NONE, 1'b0);
    while (queued < goal) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3))
          add_item(2'($urandom_range(0, 3)), rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end else begin
        fault = ($urandom_range(0, 99) < 70) ? FLT_NONE : fault_e'($urandom_range(1, 7));
        queue_exchange(rand_byte(), rand_byte(), pick_len(), pick_len(), fault,
                       $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // driver: take the accepted item at the rising edge, present the next at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && link_req.valid && link_req.ready) begin
      expected_link_out.push_back(advance_framer(req_cur));
      req_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken || !link_req.valid) begin
        req_taken = 1'b0;
        if (host_items.size() != 0 && !take_gap()) begin
          req_cur = host_items.pop_front();
          link_req.valid = 1'b1;
          link_req.command = req_cur.command;
          link_req.frame_address = req_cur.frame_address;
          link_req.frame_opcode = req_cur.frame_opcode;
          link_req.payload_length = req_cur.payload_length;
          link_req.data_byte = req_cur.data_byte;
        end else begin
          link_req.valid = 1'b0;
        end
      end
      link_rsp.ready = !take_gap();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && link_rsp.valid && link_rsp.ready) begin
      if (expected_link_out.size() == 0) begin
        flag_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = expected_link_out.pop_front();
        if (link_rsp.tx_valid !== want.tx_valid)
          flag_mismatch("tx_valid", int'(link_rsp.tx_valid), int'(want.tx_valid));
        if (link_rsp.tx_byte !== want.tx_byte)
          flag_mismatch("tx_byte", int'(link_rsp.tx_byte), int'(want.tx_byte));
        if (link_rsp.payload_valid !== want.payload_valid)
          flag_mismatch("payload_valid", int'(link_rsp.payload_valid),
                        int'(want.payload_valid));
        if (link_rsp.payload_keep !== want.payload_keep)
          flag_mismatch("payload_keep", int'(link_rsp.payload_keep), int'(want.payload_keep));
        if (link_rsp.payload_index !== want.payload_index)
          flag_mismatch("payload_index", int'(link_rsp.payload_index),
                        int'(want.payload_index));
        if (link_rsp.payload_byte !== want.payload_byte)
          flag_mismatch("payload_byte", int'(link_rsp.payload_byte), int'(want.payload_byte));
        if (link_rsp.finished !== want.finished)
          flag_mismatch("finished", int'(link_rsp.finished), int'(want.finished));
        if (link_rsp.status !== want.status)
          flag_mismatch("status", int'(link_rsp.status), int'(want.status));
        if (link_rsp.response_length !== want.response_length)
          flag_mismatch("response_length", int'(link_rsp.response_length),
                        int'(want.response_length));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (link_req.valid && link_req.ready) || (link_rsp.valid && link_rsp.ready) ||
        (cap_cfg.valid && cap_cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    link_req.valid = 1'b0;
    link_req.command = CMD_START;
    link_req.frame_address = '0;
    link_req.frame_opcode = '0;
    link_req.payload_length = '0;
    link_req.data_byte = '0;
    link_rsp.ready = 1'b0;
    cap_cfg.valid = 1'b0;
    cap_cfg.data = '0;
    req_taken = 1'b0;
    req_cur = '0;
    fr = '0;
    fr.phase = PH_IDLE;
    capacity_setting = CAP_RESET;
    no_gaps = 1'b0;
    queued = 0;
    mismatches = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // nothing to do in idle
    add_item(CMD_SLOT, 8'h00, 8'h00, 8'h00, 8'h00);
    add_item(CMD_RX, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // start while busy abandons the first exchange
    add_item(CMD_START, 8'hFF, 8'h00, 8'hFF, 8'h00);
    add_item(CMD_SLOT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // zero lengths, stray slot while receiving, clean finish
    queue_exchange(8'h00, 8'hFF, 8'd0, 8'd0, FLT_NONE, 1'b1);
    // received byte while still sending
    add_item(CMD_START, 8'h5A, 8'hA5, 8'd1, 8'h00);
    add_item(CMD_SLOT, 8'h00, 8'h00, 8'h00, 8'h00);
    add_item(CMD_RX, 8'h00, 8'h00, 8'h00, FRAME_HEAD);

    run_phase(8'd0, 90, 1'b0, 1'b0);
    run_phase(byte_t'($urandom_range(1, 6)), 90, 1'b1, 1'b0);
    run_phase(8'd128, 100, 1'b0, 1'b1);
    run_phase(8'd255, 90, 1'b0, 1'b0);
    run_phase(8'd3, 70, 1'b0, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== serial_request_response_framer_core.f =====
+incdir+src
src/srrf_pkg.sv
src/srrf_if.sv
src/srrf_step.sv
src/serial_request_response_framer_core.sv
src/srrf_checker.sv
tb/tb_serial_request_response_framer_core.sv
